/* hdl/pal_pkg.sv */
`default_nettype none

package pal_pkg;

    // operation codes carried in the mode field
    localparam logic [2:0] MODE_INS_FRONT = 3'd0;
    localparam logic [2:0] MODE_INS_BACK  = 3'd1;
    localparam logic [2:0] MODE_INS_POS   = 3'd2;
    localparam logic [2:0] MODE_REM_FRONT = 3'd3;
    localparam logic [2:0] MODE_REM_BACK  = 3'd4;
    localparam logic [2:0] MODE_REM_POS   = 3'd5;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    // fixed field widths of the stream words
    localparam int MODE_W   = 3;
    localparam int POS_W    = 10;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 10;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // fan-in of one node of the removal tree
    localparam int TREE_FANIN = 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TREE,
        S_OUT
    } t_state;

    // shift commands broadcast along the cell row
    typedef struct packed {
        logic do_ins;
        logic do_rem;
    } t_cell_ctl;

    // node count of one tree level, level 0 being the leaves
    function automatic int pal_tree_nodes(int n, int lev);
        int m;
        m = n;
        for (int l = 0; l < lev; l++) begin
            m = (m + TREE_FANIN - 1) >> 3;
        end
        return m;
    endfunction

    // number of registered levels down to a single root
    function automatic int pal_tree_levels(int n);
        int m;
        int lev;
        m   = n;
        lev = 0;
        while (m > 1 || lev == 0) begin
            m   = (m + TREE_FANIN - 1) >> 3;
            lev = lev + 1;
        end
        return lev;
    endfunction

    // flat offset of the first node of a registered level (levels from 1)
    function automatic int pal_tree_off(int n, int lev);
        int s;
        s = 0;
        for (int l = 1; l < lev; l++) begin
            s = s + pal_tree_nodes(n, l);
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* hdl/pal_cell.sv */
`default_nettype none

module pal_cell
    import pal_pkg::*;
#(
    parameter int IDX = 0,
    parameter int IW  = 10,
    parameter int W   = 32
) (
    input  wire logic          i_clk,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic [IW-1:0] i_tgt,
    input  wire logic [W-1:0]  i_value,
    input  wire logic [W-1:0]  i_left,
    input  wire logic [W-1:0]  i_right,
    output logic      [W-1:0]  o_data,
    output logic      [W-1:0]  o_leaf
);

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;
    logic         at_tgt;
    logic         past_tgt;

    assign at_tgt   = (MY_IDX == i_tgt);
    assign past_tgt = (MY_IDX > i_tgt);

    // insert: take the new word at the target, the left neighbour above it
    // remove: take the right neighbour from the target upwards
    always_comb begin
        n_data = r_data;
        if (i_ctl.do_ins) begin
            if (at_tgt) begin
                n_data = i_value;
            end else if (past_tgt) begin
                n_data = i_left;
            end
        end else if (i_ctl.do_rem) begin
            if (at_tgt || past_tgt) begin
                n_data = i_right;
            end
        end
    end

    // entry store, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // only the cell being removed feeds the collection tree
    assign o_leaf = (i_ctl.do_rem && at_tgt) ? r_data : '0;

endmodule

`default_nettype wire

/* hdl/pal_or_tree.sv */
`default_nettype none

module pal_or_tree
    import pal_pkg::*;
#(
    parameter int N = 512,
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_leaf [N],
    output logic      [W-1:0] o_root
);

    localparam int LEVELS = pal_tree_levels(N);
    localparam int TOTAL  = pal_tree_off(N, LEVELS + 1);

    logic [W-1:0] r_node [TOTAL];

    // one register stage per level, each node ORs up to eight children
    for (genvar lv = 1; lv <= LEVELS; lv++) begin : g_lev
        localparam int NI = pal_tree_nodes(N, lv - 1);
        localparam int NO = pal_tree_nodes(N, lv);
        localparam int OI = pal_tree_off(N, lv - 1);
        localparam int OO = pal_tree_off(N, lv);
        for (genvar j = 0; j < NO; j++) begin : g_node
            logic [W-1:0] n_acc;
            if (lv == 1) begin : g_leafin
                always_comb begin
                    n_acc = '0;
                    for (int k = 0; k < TREE_FANIN; k++) begin
                        if (j * TREE_FANIN + k < NI) begin
                            n_acc = n_acc | i_leaf[j * TREE_FANIN + k];
                        end
                    end
                end
            end else begin : g_nodein
                always_comb begin
                    n_acc = '0;
                    for (int k = 0; k < TREE_FANIN; k++) begin
                        if (j * TREE_FANIN + k < NI) begin
                            n_acc = n_acc | r_node[OI + j * TREE_FANIN + k];
                        end
                    end
                end
            end
            always_ff @(posedge i_clk) begin
                r_node[OO + j] <= n_acc;
            end
        end
    end

    assign o_root = r_node[TOTAL - 1];

endmodule

`default_nettype wire

/* hdl/positional_array_list_unit.sv */
// Ordered list held in a row of entry cells; the entries from the target upwards all shift at once.
// The input word is taken only in idle; the removed word then passes through
// the registered levels of the 8-ary removal tree, LEVELS deep (3 for 512
// entries), and the result word is held until the output accepts it; the
// next word is taken only once the previous result has been delivered.
// Reset clears the entry count and the control; entry cells are not cleared.
`default_nettype none

module positional_array_list_unit
    import pal_pkg::*;
#(
    parameter int LIST_DEPTH = 512,
    parameter int ENTRY_BITS = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_tvalid,
    output logic                     o_s_tready,
    // [2:0] mode, [12:3] position, [44:13] entry_value, [47:45] zero
    input  wire logic [S_DATA_W-1:0] i_s_tdata,
    output logic                     o_m_tvalid,
    input  wire logic                i_m_tready,
    // [1:0] status, [33:2] removed_value, [43:34] entry_count, [47:44] zero
    output logic      [M_DATA_W-1:0] o_m_tdata
);

    localparam int CW     = $clog2(LIST_DEPTH + 1);
    localparam int IW     = (CW > POS_W) ? CW : POS_W;
    localparam int W      = ENTRY_BITS;
    localparam int LEVELS = pal_tree_levels(LIST_DEPTH);
    localparam int WAIT_W = $clog2(LEVELS + 1);

    localparam logic [CW-1:0]     DEPTH_C  = CW'(LIST_DEPTH);
    localparam logic [WAIT_W-1:0] LEVELS_C = WAIT_W'(LEVELS);

    // input word fields
    logic [MODE_W-1:0]  in_mode;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;
    logic [W-1:0]       ins_value;

    assign in_mode  = i_s_tdata[MODE_W-1:0];
    assign in_pos   = i_s_tdata[MODE_W +: POS_W];
    assign in_value = i_s_tdata[MODE_W + POS_W +: VALUE_W];

    if (W <= VALUE_W) begin : g_vnarrow
        assign ins_value = in_value[W-1:0];
    end else begin : g_vwide
        assign ins_value = {{(W - VALUE_W){1'b0}}, in_value};
    end

    t_state            r_state;
    t_state            n_state;
    logic [WAIT_W-1:0] r_wait;
    logic [WAIT_W-1:0] n_wait;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic [STATUS_W-1:0] r_status;
    logic [COUNT_W-1:0]  r_count_out;
    logic [VALUE_W-1:0]  r_removed;

    logic              accept;
    logic [IW-1:0]     cnt_x;
    logic [IW-1:0]     pos_x;
    logic [IW-1:0]     tgt;
    logic [STATUS_W-1:0] status;
    t_cell_ctl         ctl;
    logic [W-1:0]      root;
    logic [VALUE_W-1:0] root_out;

    assign accept = i_s_tvalid && o_s_tready;
    assign cnt_x  = IW'(r_count);
    assign pos_x  = IW'(in_pos);

    // decode the operation, check it and pick the target cell
    always_comb begin
        tgt        = '0;
        status     = ST_BADPOS;
        ctl.do_ins = 1'b0;
        ctl.do_rem = 1'b0;
        case (in_mode)
            MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_POS: begin
                case (in_mode)
                    MODE_INS_FRONT: tgt = '0;
                    MODE_INS_BACK:  tgt = cnt_x;
                    default:        tgt = pos_x;
                endcase
                if (r_count == DEPTH_C) begin
                    status = ST_FULL;
                end else if (tgt > cnt_x) begin
                    status = ST_BADPOS;
                end else begin
                    status     = ST_OK;
                    ctl.do_ins = accept;
                end
            end
            MODE_REM_FRONT, MODE_REM_BACK, MODE_REM_POS: begin
                case (in_mode)
                    MODE_REM_FRONT: tgt = '0;
                    MODE_REM_BACK:  tgt = cnt_x - IW'(1);
                    default:        tgt = pos_x;
                endcase
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (tgt >= cnt_x) begin
                    status = ST_BADPOS;
                end else begin
                    status     = ST_OK;
                    ctl.do_rem = accept;
                end
            end
            default: begin
                status = ST_BADPOS;
            end
        endcase
    end

    // entry count
    always_comb begin
        n_count = r_count;
        if (ctl.do_ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.do_rem) begin
            n_count = r_count - CW'(1);
        end
    end

    // row of entry cells
    logic [W-1:0] cell_data [LIST_DEPTH];
    logic [W-1:0] cell_leaf [LIST_DEPTH];

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic [W-1:0] left_w;
        logic [W-1:0] right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid
            assign left_w = cell_data[i - 1];
        end
        if (i == LIST_DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_inner
            assign right_w = cell_data[i + 1];
        end
        pal_cell #(
            .IDX (i),
            .IW  (IW),
            .W   (W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_tgt   (tgt),
            .i_value (ins_value),
            .i_left  (left_w),
            .i_right (right_w),
            .o_data  (cell_data[i]),
            .o_leaf  (cell_leaf[i])
        );
    end

    // collect the removed word
    pal_or_tree #(
        .N (LIST_DEPTH),
        .W (W)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (cell_leaf),
        .o_root (root)
    );

    if (W >= VALUE_W) begin : g_rwide
        assign root_out = root[VALUE_W-1:0];
    end else begin : g_rnarrow
        assign root_out = {{(VALUE_W - W){1'b0}}, root};
    end

    // sequencer: take a word, wait out the tree, present the result
    always_comb begin
        n_state    = r_state;
        n_wait     = r_wait;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    n_state = S_TREE;
                    n_wait  = LEVELS_C;
                end
            end
            S_TREE: begin
                n_wait = r_wait - WAIT_W'(1);
                if (r_wait == WAIT_W'(1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
            r_count <= n_count;
        end
    end

    // result word registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= status;
            r_count_out <= COUNT_W'(n_count);
        end
        if (r_state == S_TREE && r_wait == WAIT_W'(1)) begin
            r_removed <= root_out;
        end
    end

    assign o_m_tdata = {{(M_DATA_W - STATUS_W - VALUE_W - COUNT_W){1'b0}},
                        r_count_out, r_removed, r_status};

endmodule

`default_nettype wire
